@@ rtl/core/tme_pkg.sv @@
// ----------------------------------------------------------------------------
// tme_pkg
// Shared types, sizes and opcodes of the tape machine executor.
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int TAPE_DEPTH    = 65536;
  localparam int PROGRAM_DEPTH = 65536;
  localparam int TAPE_AW       = $clog2(TAPE_DEPTH);
  localparam int PC_W          = $clog2(PROGRAM_DEPTH);

  typedef logic [TAPE_AW-1:0] tape_addr_t;
  typedef logic [PC_W-1:0]    pc_t;
  typedef logic [3:0]         op_t;
  typedef logic signed [16:0] operand_t;
  typedef logic signed [10:0] offset_t;
  typedef logic [7:0]         byte_t;
  typedef logic [15:0]        word_t;

  localparam word_t START_RESET = 16'd32768;

  localparam op_t OP_ADD   = 4'd0;
  localparam op_t OP_MOVE  = 4'd1;
  localparam op_t OP_PUT   = 4'd2;
  localparam op_t OP_GET   = 4'd3;
  localparam op_t OP_JZ    = 4'd4;
  localparam op_t OP_JNZ   = 4'd5;
  localparam op_t OP_CLEAR = 4'd6;
  localparam op_t OP_MUL   = 4'd7;
  localparam op_t OP_NOP   = 4'd8;
  localparam op_t OP_HALT  = 4'd9;

  typedef struct packed {
    word_t next_pc;
    logic  put_valid;
    byte_t put_byte;
    logic  halted;
  } result_t;

endpackage

@@ rtl/core/tme_in_if.sv @@
// ----------------------------------------------------------------------------
// tme_in_if
// Instruction channel: valid/ready handshake with one compiled instruction.
// ----------------------------------------------------------------------------
interface tme_in_if;
  logic               valid;
  logic               ready;
  tme_pkg::op_t       req_type;
  tme_pkg::operand_t  operand;
  tme_pkg::offset_t   cell_offset;
  tme_pkg::byte_t     in_byte;
  logic               in_eof;

  modport source (output valid, req_type, operand, cell_offset, in_byte, in_eof,
                  input ready);
  modport sink   (input valid, req_type, operand, cell_offset, in_byte, in_eof,
                  output ready);
endinterface

@@ rtl/core/tme_out_if.sv @@
// ----------------------------------------------------------------------------
// tme_out_if
// Result channel: valid/ready handshake with one execution result.
// ----------------------------------------------------------------------------
interface tme_out_if;
  logic           valid;
  logic           ready;
  tme_pkg::word_t next_pc;
  logic           put_valid;
  tme_pkg::byte_t put_byte;
  logic           halted;

  modport source (output valid, next_pc, put_valid, put_byte, halted, input ready);
  modport sink   (input valid, next_pc, put_valid, put_byte, halted, output ready);
endinterface

@@ rtl/core/tme_ram.sv @@
// ----------------------------------------------------------------------------
// tme_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tape_machine_executor.sv @@
// ----------------------------------------------------------------------------
// tape_machine_executor
// Executes one compiled tape-machine instruction per transaction against a
// byte tape held in an on-chip RAM.
// ----------------------------------------------------------------------------
// After reset the tape RAM is cleared one cell a cycle, during which no
// instruction is accepted (start_position writes are taken). The cell under
// the data pointer is held in a register, so add, put, get, jumps, clear,
// nop and halt need no tape read; move then reloads the current cell from
// the tape RAM read port before the next instruction is taken; mul reads the
// target cell and then writes it back on the single write port. A
// start_position write moves the data pointer and blocks input while the
// current cell reloads. Results pass through a two-entry output buffer,
// so one more instruction is accepted while a result waits to be taken.
// ----------------------------------------------------------------------------
module tape_machine_executor (
  input  logic           clk,
  input  logic           rst_n,
  tme_in_if.sink         in_ch,
  tme_out_if.source      out_ch,
  input  logic           cfg_we,
  input  tme_pkg::word_t cfg_wdata
);

  localparam tme_pkg::tape_addr_t CLR_LAST = tme_pkg::tape_addr_t'(tme_pkg::TAPE_DEPTH - 1);

  tme_pkg::tape_addr_t dp_r, dp_nxt;
  tme_pkg::pc_t        pc_r, pc_nxt;
  logic                halt_r, halt_nxt;
  tme_pkg::byte_t      cur_r, cur_nxt;

  logic                clr_active_r;
  tme_pkg::tape_addr_t clr_addr_r;
  logic                reload_r, reload_nxt;
  logic                mul_r, mul_nxt;
  tme_pkg::tape_addr_t tgt_r, tgt_nxt;
  tme_pkg::byte_t      prod_r, prod_nxt;
  tme_pkg::byte_t      mul_sum;
  tme_pkg::byte_t      op8;

  logic                ram_we;
  tme_pkg::tape_addr_t ram_waddr;
  tme_pkg::byte_t      ram_wdata;
  tme_pkg::tape_addr_t ram_raddr;
  tme_pkg::byte_t      ram_rdata;

  logic                in_fire;
  logic                out_fire;
  tme_pkg::result_t    res_new;
  tme_pkg::result_t    out_res_r;
  tme_pkg::result_t    skid_res_r;
  logic                out_valid_r;
  logic                skid_valid_r;

  tme_ram #(
    .WIDTH (8),
    .DEPTH (tme_pkg::TAPE_DEPTH)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = !clr_active_r && !reload_r && !mul_r && !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_pc   = out_res_r.next_pc;
  assign out_ch.put_valid = out_res_r.put_valid;
  assign out_ch.put_byte  = out_res_r.put_byte;
  assign out_ch.halted    = out_res_r.halted;

  assign op8     = in_ch.operand[7:0];
  assign mul_sum = ram_rdata + prod_r;

  always_comb begin
    dp_nxt     = dp_r;
    pc_nxt     = pc_r;
    halt_nxt   = halt_r;
    cur_nxt    = cur_r;
    reload_nxt = 1'b0;
    mul_nxt    = 1'b0;
    tgt_nxt    = dp_r + tme_pkg::tape_addr_t'(in_ch.cell_offset);
    prod_nxt   = tme_pkg::byte_t'(cur_r * op8);
    ram_we     = 1'b0;
    ram_waddr  = dp_r;
    ram_wdata  = cur_r;
    ram_raddr  = dp_r;

    res_new.next_pc   = tme_pkg::word_t'(pc_r);
    res_new.put_valid = 1'b0;
    res_new.put_byte  = '0;
    res_new.halted    = halt_r;

    if (in_fire && !halt_r) begin
      pc_nxt = pc_r + 1'b1;
      case (in_ch.req_type)
        tme_pkg::OP_ADD: begin
          cur_nxt = cur_r + op8;
          ram_we  = 1'b1;
        end
        tme_pkg::OP_MOVE: begin
          dp_nxt     = dp_r + tme_pkg::tape_addr_t'(in_ch.operand);
          ram_raddr  = dp_nxt;
          reload_nxt = 1'b1;
        end
        tme_pkg::OP_PUT: begin
          res_new.put_valid = 1'b1;
          res_new.put_byte  = cur_r;
        end
        tme_pkg::OP_GET: begin
          if (!in_ch.in_eof) begin
            cur_nxt = in_ch.in_byte;
            ram_we  = 1'b1;
          end
        end
        tme_pkg::OP_JZ: begin
          if (cur_r == '0) pc_nxt = tme_pkg::pc_t'(in_ch.operand);
        end
        tme_pkg::OP_JNZ: begin
          if (cur_r != '0) pc_nxt = tme_pkg::pc_t'(in_ch.operand);
        end
        tme_pkg::OP_CLEAR: begin
          cur_nxt = '0;
          ram_we  = 1'b1;
        end
        tme_pkg::OP_MUL: begin
          ram_raddr = tgt_nxt;
          mul_nxt   = 1'b1;
        end
        tme_pkg::OP_HALT: begin
          halt_nxt = 1'b1;
          pc_nxt   = pc_r;
        end
        default: ;
      endcase
      ram_wdata         = cur_nxt;
      res_new.next_pc   = tme_pkg::word_t'(pc_nxt);
      res_new.halted    = halt_nxt;
    end

    // mul write-back phase: write back the target cell
    if (mul_r) begin
      ram_we    = 1'b1;
      ram_waddr = tgt_r;
      ram_wdata = mul_sum;
      if (tgt_r == dp_r) cur_nxt = mul_sum;
    end

    if (reload_r) begin
      cur_nxt = ram_rdata;
    end

    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end

    // a start_position write reloads the current cell, but not while the tape is being cleared
    if (cfg_we) begin
      dp_nxt     = tme_pkg::tape_addr_t'(cfg_wdata);
      ram_raddr  = dp_nxt;
      reload_nxt = !clr_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r         <= tme_pkg::tape_addr_t'(tme_pkg::START_RESET);
      pc_r         <= '0;
      halt_r       <= 1'b0;
      cur_r        <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      reload_r     <= 1'b0;
      mul_r        <= 1'b0;
    end else begin
      dp_r     <= dp_nxt;
      pc_r     <= pc_nxt;
      halt_r   <= halt_nxt;
      cur_r    <= cur_nxt;
      reload_r <= reload_nxt;
      mul_r    <= mul_nxt;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == CLR_LAST) clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    prod_r <= prod_nxt;
  end

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r && out_fire) begin
        out_res_r    <= skid_res_r;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        if (!out_valid_r || out_fire) begin
          out_res_r   <= res_new;
          out_valid_r <= 1'b1;
        end else begin
          skid_res_r   <= res_new;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/tme_chk.sv @@
// ----------------------------------------------------------------------------
// tme_chk
// Port-level checks of the tape machine executor, bound to the top level.
// ----------------------------------------------------------------------------
module tme_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input tme_pkg::op_t   in_req_type,
  input logic           out_valid,
  input logic           out_ready,
  input tme_pkg::word_t out_next_pc,
  input logic           out_put_valid,
  input tme_pkg::byte_t out_put_byte,
  input logic           out_halted
);

  logic           in_fire;
  logic           out_fire;
  logic           halt_in_r;
  logic           seen_halt_r;
  tme_pkg::word_t halt_pc_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_in_r   <= 1'b0;
      seen_halt_r <= 1'b0;
    end else begin
      if (in_fire && in_req_type == tme_pkg::OP_HALT) halt_in_r <= 1'b1;
      if (out_fire && out_halted && !seen_halt_r) begin
        seen_halt_r <= 1'b1;
        halt_pc_r   <= out_next_pc;
      end
    end
  end

  // once halted, every later result repeats the halt address
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && seen_halt_r) |-> (out_halted && out_next_pc == halt_pc_r))
    else $error("result after halt changed");

  a_put_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_put_valid) |-> (out_put_byte == '0))
    else $error("put_byte set without put_valid");

  // move and mul hold off the next instruction in the cycle after they are accepted
  a_two_cycle_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !halt_in_r &&
     (in_req_type == tme_pkg::OP_MOVE || in_req_type == tme_pkg::OP_MUL))
    |=> !in_ready)
    else $error("instruction accepted during move or mul");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("no result after accepted transaction");

endmodule

bind tape_machine_executor tme_chk u_tme_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_req_type   (in_ch.req_type),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_next_pc   (out_ch.next_pc),
  .out_put_valid (out_ch.put_valid),
  .out_put_byte  (out_ch.put_byte),
  .out_halted    (out_ch.halted)
);
